// File: rtl/core/bspw_pkg.sv
// Shared types, constants and the conditional-mark function for the binary
// shrink pass window core. No dependencies.
`default_nettype none

package bspw_pkg;

    localparam int WIN_WIDTH = 25;
    localparam int BRD_WIDTH = 4;
    localparam int NB_COUNT  = 8;
    localparam int WIN_SIDE  = 5;

    // Border flag bit positions
    localparam int BRD_TOP    = 0;
    localparam int BRD_BOTTOM = 1;
    localparam int BRD_LEFT   = 2;
    localparam int BRD_RIGHT  = 3;

    localparam int MID_DEPTH_DEFAULT = 4;
    localparam int OUT_DEPTH_DEFAULT = 2;

    // Classified beat handed from front to back
    typedef struct packed {
        logic                centre;
        logic                cmark;
        logic [NB_COUNT-1:0] nmark;   // MSB top-left .. LSB bottom-right
    } mid_item_t;

    typedef struct packed {
        logic out_pixel;
        logic marked;
        logic changed;
    } result_t;

    // Bond: corners weigh 1, edge neighbours weigh 2
    function automatic logic [3:0] bond_of(input logic [NB_COUNT-1:0] code);
        logic [3:0] b;
        b = 4'({3'b000, code[7]} + {3'b000, code[5]} + {3'b000, code[2]}
               + {3'b000, code[0]})
          + 4'({2'b00, code[6], 1'b0} + {2'b00, code[4], 1'b0}
               + {2'b00, code[3], 1'b0} + {2'b00, code[1], 1'b0});
        return b;
    endfunction

    // True where the neighbour code hits a conditional shrink pattern
    function automatic logic cond_hit(input logic [NB_COUNT-1:0] code);
        logic [3:0] tb;
        case (code)
            8'd1, 8'd4, 8'd32, 8'd128:                               tb = 4'd1;
            8'd2, 8'd8, 8'd16, 8'd64:                                tb = 4'd2;
            8'd40, 8'd96, 8'd192, 8'd144, 8'd20, 8'd6, 8'd3, 8'd9:   tb = 4'd3;
            8'd41, 8'd224, 8'd148, 8'd7:                             tb = 4'd4;
            8'd200, 8'd73, 8'd112, 8'd42, 8'd104, 8'd208, 8'd22, 8'd11:
                                                                     tb = 4'd5;
            8'd201, 8'd116, 8'd232, 8'd105, 8'd240,
            8'd212, 8'd150, 8'd23, 8'd15, 8'd43:                     tb = 4'd6;
            8'd233, 8'd244, 8'd151, 8'd47:                           tb = 4'd7;
            8'd107, 8'd248, 8'd214, 8'd31:                           tb = 4'd8;
            8'd235, 8'd111, 8'd252, 8'd249, 8'd246, 8'd215, 8'd159, 8'd63:
                                                                     tb = 4'd9;
            8'd239, 8'd253, 8'd247, 8'd191:                          tb = 4'd10;
            default:                                                 tb = 4'd0;
        endcase
        return (tb != 4'd0) && (tb == bond_of(code));
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/binary_shrink_pass_window_core.sv
// Binary shrink pass window core: one shrinking pass per pixel window.
// Throughput: one beat per cycle in and out, sustained while pop keeps up.
// Path: a taken beat passes the front register, the mid queue, the back
// register and the result queue before it reaches the result ports.
// Reset: rst_n clears every queue and stage valid; no clearing pass.
// Depends on bspw_pkg, bspw_front, bspw_fifo and bspw_back.
`default_nettype none

module binary_shrink_pass_window_core #(
    parameter int MID_DEPTH = bspw_pkg::MID_DEPTH_DEFAULT,
    parameter int OUT_DEPTH = bspw_pkg::OUT_DEPTH_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [bspw_pkg::WIN_WIDTH-1:0] window_bits,
    input  wire logic [bspw_pkg::BRD_WIDTH-1:0] border_flags,
    output logic                                empty,
    input  wire logic                           pop,
    output logic                                out_pixel,
    output logic                                marked,
    output logic                                changed
);

    localparam int MidW = $bits(bspw_pkg::mid_item_t);
    localparam int ResW = $bits(bspw_pkg::result_t);

    logic                 front_ready;
    logic                 front_valid;
    bspw_pkg::mid_item_t  front_item;
    logic                 mid_full;
    logic                 mid_empty;
    logic [MidW-1:0]      mid_rdata;
    bspw_pkg::mid_item_t  mid_item;
    logic                 back_ready;
    logic                 back_valid;
    bspw_pkg::result_t    back_res;
    logic                 res_full;
    logic [ResW-1:0]      res_rdata;
    bspw_pkg::result_t    res_head;

    // Front: classify each window into conditional marks, one beat a cycle while the mid queue has room
    bspw_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (push),
        .in_ready     (front_ready),
        .window_bits  (window_bits),
        .border_flags (border_flags),
        .out_valid    (front_valid),
        .out_ready    (!mid_full),
        .out_item     (front_item)
    );

    assign full = !front_ready;

    // Decoupling queue: lets front and back stall independently
    bspw_fifo #(
        .Width (MidW),
        .Depth (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_valid),
        .wdata (front_item),
        .full  (mid_full),
        .pop   (back_ready),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    assign mid_item = bspw_pkg::mid_item_t'(mid_rdata);

    // Back: unconditional masks decide keep or delete
    bspw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!mid_empty),
        .in_ready  (back_ready),
        .in_item   (mid_item),
        .out_valid (back_valid),
        .out_ready (!res_full),
        .out_res   (back_res)
    );

    // Result queue: hold finished beats until popped
    bspw_fifo #(
        .Width (ResW),
        .Depth (OUT_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_valid),
        .wdata (back_res),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign res_head  = bspw_pkg::result_t'(res_rdata);
    assign out_pixel = res_head.out_pixel;
    assign marked    = res_head.marked;
    assign changed   = res_head.changed;

    // A pixel only ever changes by a conditional deletion
    a_change_needs_mark : assert property (@(posedge clk) disable iff (!rst_n)
        !empty && changed |-> marked)
        else $error("changed result without conditional mark");

    // Shrinking never turns background into object
    a_change_is_delete : assert property (@(posedge clk) disable iff (!rst_n)
        !empty && changed |-> !out_pixel)
        else $error("changed result grew a pixel");

    // An accepted beat must sit in the front register next cycle
    a_front_loaded : assert property (@(posedge clk) disable iff (!rst_n)
        push && !full |=> front_valid)
        else $error("accepted beat lost in front stage");

    // A back result that the result queue refuses must stay put
    a_back_holds : assert property (@(posedge clk) disable iff (!rst_n)
        back_valid && res_full |=> back_valid && $stable(back_res))
        else $error("back stage dropped a stalled result");

endmodule

`default_nettype wire

// File: rtl/core/bspw_fifo.sv
// Small synchronous queue of flip-flops, used between front and back and
// at the result side. Depends on nothing.
`default_nettype none

module bspw_fifo #(
    parameter int Width = 8,
    parameter int Depth = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [Width-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [Width-1:0]      rdata,
    output logic                  empty
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    logic [Width-1:0] mem [Depth];
    logic [PtrW-1:0]  wptr_reg, wptr_next;
    logic [PtrW-1:0]  rptr_reg, rptr_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CntW'(Depth));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PtrW'(Depth - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PtrW'(Depth - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bspw_front.sv
// Front end: takes window beats and finds the conditional marks of the
// centre and its neighbours. Depends on bspw_pkg.
`default_nettype none

module bspw_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [bspw_pkg::WIN_WIDTH-1:0] window_bits,
    input  wire logic [bspw_pkg::BRD_WIDTH-1:0] border_flags,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output bspw_pkg::mid_item_t               out_item
);

    logic [8:0]                       mark;     // 3x3 inner block, row-major
    logic [bspw_pkg::NB_COUNT-1:0]    nb_mark;
    logic [bspw_pkg::NB_COUNT-1:0]    outside;
    bspw_pkg::mid_item_t              item_next, item_reg;
    logic                             valid_reg, valid_next;
    logic                             take;

    // Conditional mark of each inner pixel, all nine side by side
    always_comb
    begin
        logic [bspw_pkg::NB_COUNT-1:0] code;
        int base;
        code = '0;
        base = 0;
        for (int r = 1; r <= 3; r++)
        begin
            for (int c = 1; c <= 3; c++)
            begin
                base = bspw_pkg::WIN_SIDE * r + c;
                code = {window_bits[base - 6], window_bits[base - 5],
                        window_bits[base - 4], window_bits[base - 1],
                        window_bits[base + 1], window_bits[base + 4],
                        window_bits[base + 5], window_bits[base + 6]};
                mark[(r - 1) * 3 + (c - 1)] = window_bits[base]
                                              && bspw_pkg::cond_hit(code);
            end
        end
    end

    // Drop marks of neighbours that lie beyond a flagged border
    always_comb
    begin
        outside[7] = border_flags[bspw_pkg::BRD_TOP]    || border_flags[bspw_pkg::BRD_LEFT];
        outside[6] = border_flags[bspw_pkg::BRD_TOP];
        outside[5] = border_flags[bspw_pkg::BRD_TOP]    || border_flags[bspw_pkg::BRD_RIGHT];
        outside[4] = border_flags[bspw_pkg::BRD_LEFT];
        outside[3] = border_flags[bspw_pkg::BRD_RIGHT];
        outside[2] = border_flags[bspw_pkg::BRD_BOTTOM] || border_flags[bspw_pkg::BRD_LEFT];
        outside[1] = border_flags[bspw_pkg::BRD_BOTTOM];
        outside[0] = border_flags[bspw_pkg::BRD_BOTTOM] || border_flags[bspw_pkg::BRD_RIGHT];
        nb_mark = {mark[0], mark[1], mark[2], mark[3],
                   mark[5], mark[6], mark[7], mark[8]} & ~outside;
    end

    assign item_next.centre = window_bits[12];
    assign item_next.cmark  = mark[4];
    assign item_next.nmark  = nb_mark;

    assign in_ready  = !valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bspw_back.sv
// Back end: applies the unconditional shrink masks to the neighbour marks
// and forms the result beat. Depends on bspw_pkg.
`default_nettype none

module bspw_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire bspw_pkg::mid_item_t  in_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output bspw_pkg::result_t         out_res
);

    logic [bspw_pkg::NB_COUNT-1:0] m;
    logic                          hit;
    logic                          pix;
    bspw_pkg::result_t             res_next, res_reg;
    logic                          valid_reg, valid_next;
    logic                          take;

    // m[0] is top-left, m[7] bottom-right
    always_comb
    begin
        for (int k = 0; k < bspw_pkg::NB_COUNT; k++)
        begin
            m[k] = in_item.nmark[bspw_pkg::NB_COUNT - 1 - k];
        end
    end

    always_comb
    begin
        hit = 1'b0;
        // spur and single 4-connection
        if (in_item.nmark == 8'd32 || in_item.nmark == 8'd128
            || in_item.nmark == 8'd2 || in_item.nmark == 8'd8)
            hit = 1'b1;
        // 4-connected offset
        if (in_item.nmark == 8'd112 || in_item.nmark == 8'd200
            || in_item.nmark == 8'd73 || in_item.nmark == 8'd42)
            hit = 1'b1;
        // spur corner cluster
        if (!m[0] && !m[3] && !m[6] && !m[7] && m[2] && m[5] && (m[1] || m[4])) hit = 1'b1;
        if (!m[2] && !m[4] && !m[5] && !m[6] && m[0] && m[7] && (m[1] || m[3])) hit = 1'b1;
        if (!m[0] && !m[1] && !m[4] && !m[7] && m[2] && m[5] && (m[3] || m[6])) hit = 1'b1;
        if (!m[1] && !m[2] && !m[3] && !m[5] && m[0] && m[7] && (m[4] || m[6])) hit = 1'b1;
        // corner cluster
        if (m[0] && m[1] && m[3]) hit = 1'b1;
        // tee branch
        if (!m[2] && !m[6] && !m[7] && m[1] && m[3] && m[4]) hit = 1'b1;
        if (!m[0] && !m[5] && !m[6] && m[1] && m[3] && m[4]) hit = 1'b1;
        if (!m[0] && !m[1] && !m[5] && m[6] && m[3] && m[4]) hit = 1'b1;
        if (!m[1] && !m[2] && !m[7] && m[6] && m[3] && m[4]) hit = 1'b1;
        if (!m[4] && !m[5] && !m[7] && m[1] && m[3] && m[6]) hit = 1'b1;
        if (!m[0] && !m[2] && !m[4] && m[1] && m[3] && m[6]) hit = 1'b1;
        if (!m[0] && !m[2] && !m[3] && m[1] && m[4] && m[6]) hit = 1'b1;
        if (!m[3] && !m[5] && !m[7] && m[1] && m[4] && m[6]) hit = 1'b1;
        // vee branch
        if (m[0] && m[2] && (m[5] || m[6] || m[7])) hit = 1'b1;
        if (m[0] && m[5] && (m[2] || m[4] || m[7])) hit = 1'b1;
        if (m[5] && m[7] && (m[0] || m[1] || m[2])) hit = 1'b1;
        if (m[2] && m[7] && (m[0] || m[3] || m[5])) hit = 1'b1;
        // diagonal branch
        if (m[1] && m[4] && m[5] && !m[2] && !m[3] && !m[6]) hit = 1'b1;
        if (m[1] && m[3] && m[7] && !m[0] && !m[4] && !m[6]) hit = 1'b1;
        if (m[2] && m[3] && m[6] && !m[1] && !m[4] && !m[5]) hit = 1'b1;
        if (m[0] && m[4] && m[6] && !m[1] && !m[3] && !m[7]) hit = 1'b1;
    end

    // Keep a marked centre only on a mask hit
    assign pix = in_item.cmark ? hit : in_item.centre;

    assign res_next.out_pixel = pix;
    assign res_next.marked    = in_item.cmark;
    assign res_next.changed   = pix ^ in_item.centre;

    assign in_ready  = !valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire
